@@ hdl/ucdd_pkg.sv @@
// ----------------------------------------------------------------------------
// ucdd_pkg: shared types and constants for the command digit display
// Parser states, command structs, segment and reply lookup functions.
// ----------------------------------------------------------------------------
package ucdd_pkg;

  localparam int unsigned NUM_DIGITS_DEF = 8;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned ANODE_W        = 8;
  localparam int unsigned REPLY_IDX_W    = 2;

  localparam logic [DIGIT_W-1:0]     CODE_BLANK = 4'hA;
  localparam logic [BYTE_W-1:0]      CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0]      CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0]      CHAR_A     = 8'h41;
  localparam logic [BYTE_W-1:0]      CHAR_N     = 8'h4E;
  localparam logic [BYTE_W-1:0]      CHAR_C     = 8'h43;
  localparam logic [BYTE_W-1:0]      CHAR_O     = 8'h4F;
  localparam logic [BYTE_W-1:0]      CHAR_K     = 8'h4B;
  localparam logic [REPLY_IDX_W-1:0] REPLY_LAST = 2'd3;

  localparam logic KIND_DISPLAY = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;
  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_TWAIT,
    PS_DIGITS,
    PS_CRWAIT,
    PS_LFWAIT
  } parser_state_e;

  typedef struct packed {
    logic blank;
    logic shift;
    logic reply;
  } parser_out_t;

  typedef struct packed {
    logic blank;
    logic shift;
    logic tick;
  } cell_cmd_t;

  // Active-low segment patterns; every code from ten upwards is blank.
  function automatic logic [BYTE_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] code);
    logic [BYTE_W-1:0] pat;
    case (code)
      4'd0:    pat = 8'h01;
      4'd1:    pat = 8'h4F;
      4'd2:    pat = 8'h12;
      4'd3:    pat = 8'h06;
      4'd4:    pat = 8'h4C;
      4'd5:    pat = 8'h24;
      4'd6:    pat = 8'h20;
      4'd7:    pat = 8'h0F;
      4'd8:    pat = 8'h00;
      4'd9:    pat = 8'h04;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

  function automatic logic [BYTE_W-1:0] reply_byte(input logic [REPLY_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      2'd0:    ch = CHAR_O;
      2'd1:    ch = CHAR_K;
      2'd2:    ch = CHAR_CR;
      default: ch = CHAR_LF;
    endcase
    return ch;
  endfunction

endpackage

@@ hdl/ucdd_in_if.sv @@
// ----------------------------------------------------------------------------
// ucdd_in_if: input channel of the command digit display
// Carries a received byte or a scan tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucdd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

@@ hdl/ucdd_out_if.sv @@
// ----------------------------------------------------------------------------
// ucdd_out_if: result channel of the command digit display
// Carries a display drive update or a reply byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucdd_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] segments;
  logic [7:0] anode_select;
  logic [7:0] tx_byte;
  logic       last;

  modport source (
    output valid, output result_kind, output segments, output anode_select,
    output tx_byte, output last, input ready
  );
  modport sink (
    input valid, input result_kind, input segments, input anode_select,
    input tx_byte, input last, output ready
  );
endinterface

@@ hdl/ucdd_parser.sv @@
// ----------------------------------------------------------------------------
// ucdd_parser: serial command parser
// Five-state machine that turns received bytes into blank, shift and reply
// commands.
// ----------------------------------------------------------------------------
module ucdd_parser import ucdd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [BYTE_W-1:0]  byte_i,
  output parser_out_t        cmd_o
);

  parser_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. The T and CR wait states take any byte, and so does the LF
  // wait state, which closes the command.
  always_comb begin
    state_d = state_q;
    if (byte_valid_i) begin
      case (state_q)
        PS_IDLE: begin
          if (byte_i == CHAR_A) begin
            state_d = PS_TWAIT;
          end else if (byte_i == CHAR_N) begin
            state_d = PS_DIGITS;
          end else if (byte_i == CHAR_C) begin
            state_d = PS_CRWAIT;
          end
        end
        PS_TWAIT:  state_d = PS_CRWAIT;
        PS_DIGITS: begin
          if (byte_i == CHAR_CR) begin
            state_d = PS_LFWAIT;
          end
        end
        PS_CRWAIT: state_d = PS_LFWAIT;
        PS_LFWAIT: state_d = PS_IDLE;
        default:   state_d = PS_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    if (byte_valid_i) begin
      case (state_q)
        PS_IDLE:   cmd_o.blank = (byte_i == CHAR_N) || (byte_i == CHAR_C);
        PS_DIGITS: cmd_o.shift = (byte_i != CHAR_CR);
        PS_LFWAIT: cmd_o.reply = 1'b1;
        default:   cmd_o = '0;
      endcase
    end
  end

endmodule

@@ hdl/ucdd_digit_cell.sv @@
// ----------------------------------------------------------------------------
// ucdd_digit_cell: one digit position of the display row
// Holds a digit code and a scan token; both move to the next cell in the row.
// ----------------------------------------------------------------------------
module ucdd_digit_cell import ucdd_pkg::*; #(
  parameter logic [DIGIT_W-1:0] RESET_CODE  = '0,
  parameter logic               RESET_TOKEN = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic [DIGIT_W-1:0] digit_i,
  input  logic               token_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               token_o,
  output logic               sel_o,
  output logic [DIGIT_W-1:0] sel_code_o
);

  logic [DIGIT_W-1:0] digit_q;
  logic               token_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= RESET_CODE;
      token_q <= RESET_TOKEN;
    end else begin
      if (cmd_i.blank) begin
        digit_q <= CODE_BLANK;
      end else if (cmd_i.shift) begin
        digit_q <= digit_i;
      end
      if (cmd_i.tick) begin
        token_q <= token_i;
      end
    end
  end

  // The incoming token marks the digit that the next scan tick selects.
  assign sel_o      = token_i;
  assign sel_code_o = digit_q & {DIGIT_W{token_i}};
  assign digit_o    = digit_q;
  assign token_o    = token_q;

endmodule

@@ hdl/uart_command_digit_display_unit.sv @@
// ----------------------------------------------------------------------------
// uart_command_digit_display_unit: command-driven multiplexed digit display
// Output: each result is registered, presented the cycle after its input transfer.
// Throughput: one item per cycle while the output is ready; a command-closing byte
// yields four reply transfers, one per cycle as taken; the next input waits for the last.
// Reset: asynchronous; digits load 5,6,7,... and the scan token sits on the
// top digit, so the first tick shows digit 0.
// ----------------------------------------------------------------------------
module uart_command_digit_display_unit import ucdd_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucdd_in_if.sink     in_i,
  ucdd_out_if.source  out_o
);

  logic in_fire;
  logic out_fire;
  logic tick;
  logic byte_stb;

  parser_out_t pcmd;
  cell_cmd_t   ccmd;

  logic [DIGIT_W-1:0] digit    [NUM_DIGITS];
  logic               token    [NUM_DIGITS];
  logic               sel      [NUM_DIGITS];
  logic [DIGIT_W-1:0] sel_code [NUM_DIGITS];

  logic [DIGIT_W-1:0] next_code;
  logic [ANODE_W-1:0] next_anode;

  logic                   valid_q,  valid_d;
  logic                   kind_q,   kind_d;
  logic [BYTE_W-1:0]      seg_q,    seg_d;
  logic [ANODE_W-1:0]     anode_q,  anode_d;
  logic [BYTE_W-1:0]      tx_q,     tx_d;
  logic                   last_q,   last_d;
  logic [REPLY_IDX_W-1:0] ridx_q,   ridx_d;
  logic [REPLY_IDX_W-1:0] ridx_inc;

  // A new item is taken when the result register is empty or its final
  // transfer completes in this cycle.
  assign in_i.ready = !valid_q || (out_o.ready && last_q);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = valid_q && out_o.ready;
  assign tick       = in_fire && (in_i.operation == OP_TICK);
  assign byte_stb   = in_fire && (in_i.operation == OP_BYTE);

  ucdd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_stb),
    .byte_i       (in_i.rx_byte),
    .cmd_o        (pcmd)
  );

  assign ccmd.blank = pcmd.blank;
  assign ccmd.shift = pcmd.shift;
  assign ccmd.tick  = tick;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    localparam logic [DIGIT_W-1:0] RstCode = DIGIT_W'((5 + i) % 10);
    localparam logic               RstTok  = (i == NUM_DIGITS - 1);

    logic [DIGIT_W-1:0] din;
    logic               tin;

    if (i == 0) begin : g_head
      assign din = in_i.rx_byte[DIGIT_W-1:0];
      assign tin = token[NUM_DIGITS-1];
    end else begin : g_body
      assign din = digit[i-1];
      assign tin = token[i-1];
    end

    ucdd_digit_cell #(
      .RESET_CODE  (RstCode),
      .RESET_TOKEN (RstTok)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (ccmd),
      .digit_i    (din),
      .token_i    (tin),
      .digit_o    (digit[i]),
      .token_o    (token[i]),
      .sel_o      (sel[i]),
      .sel_code_o (sel_code[i])
    );
  end

  // Only one cell is selected, so an OR over the row picks its code.
  always_comb begin
    next_code = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      next_code = next_code | sel_code[i];
    end
  end

  // Digits beyond the eighth have no anode line.
  for (genvar j = 0; j < ANODE_W; j++) begin : g_anode
    if (j < NUM_DIGITS) begin : g_drv
      assign next_anode[j] = sel[j];
    end else begin : g_off
      assign next_anode[j] = 1'b0;
    end
  end

  assign ridx_inc = ridx_q + 1'b1;

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    seg_d   = seg_q;
    anode_d = anode_q;
    tx_d    = tx_q;
    last_d  = last_q;
    ridx_d  = ridx_q;
    if (out_fire) begin
      valid_d = 1'b0;
      if (!last_q) begin
        // Step through the remaining reply bytes.
        valid_d = 1'b1;
        ridx_d  = ridx_inc;
        tx_d    = reply_byte(ridx_inc);
        last_d  = (ridx_inc == REPLY_LAST);
      end
    end
    if (tick) begin
      valid_d = 1'b1;
      kind_d  = KIND_DISPLAY;
      seg_d   = seg_pattern(next_code);
      anode_d = next_anode;
      tx_d    = '0;
      last_d  = 1'b1;
    end else if (byte_stb && pcmd.reply) begin
      valid_d = 1'b1;
      kind_d  = KIND_REPLY;
      seg_d   = '0;
      anode_d = '0;
      ridx_d  = '0;
      tx_d    = reply_byte('0);
      last_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b1;
      ridx_q  <= '0;
    end else begin
      valid_q <= valid_d;
      last_q  <= last_d;
      ridx_q  <= ridx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    seg_q   <= seg_d;
    anode_q <= anode_d;
    tx_q    <= tx_d;
  end

  assign out_o.valid        = valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.segments     = seg_q;
  assign out_o.anode_select = anode_q;
  assign out_o.tx_byte      = tx_q;
  assign out_o.last         = last_q;

endmodule
